[rtl/core/acos_pkg.sv]
package acos_pkg;

    // Default widths for the top-level parameters
    localparam int STEP_INDEX_WIDTH_DEF = 10;
    localparam int TIMER_WIDTH_DEF      = 16;

    // Fixed field widths
    localparam int LIMIT_WIDTH     = 15;
    localparam int STEPS_WIDTH     = 10;
    localparam int PERIOD_WIDTH    = 8;
    localparam int WAIT_WIDTH      = 16;
    localparam int ANGLE_WIDTH     = 8;
    localparam int CURRENT_WIDTH   = 16;
    localparam int COMMAND_WIDTH   = 3;
    localparam int ACTION_WIDTH    = 2;
    localparam int ERROR_WIDTH     = 3;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    // Actions
    localparam logic [ACTION_WIDTH-1:0] ACT_COMMAND = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_TICK    = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_FAULT   = 2'd2;

    // Commands
    localparam logic [COMMAND_WIDTH-1:0] CMD_NONE       = 3'd0;
    localparam logic [COMMAND_WIDTH-1:0] CMD_GRIP_OPEN  = 3'd1;
    localparam logic [COMMAND_WIDTH-1:0] CMD_GRIP_CLOSE = 3'd2;
    localparam logic [COMMAND_WIDTH-1:0] CMD_FEED_OPEN  = 3'd3;
    localparam logic [COMMAND_WIDTH-1:0] CMD_FEED_CLOSE = 3'd4;
    localparam logic [COMMAND_WIDTH-1:0] CMD_STEP_DOWN  = 3'd5;
    localparam logic [COMMAND_WIDTH-1:0] CMD_STEP_UP    = 3'd6;

    // Error codes
    localparam logic [ERROR_WIDTH-1:0] ERR_OK      = 3'd0;
    localparam logic [ERROR_WIDTH-1:0] ERR_STEPPER = 3'd1;
    localparam logic [ERROR_WIDTH-1:0] ERR_GRIPPER = 3'd2;
    localparam logic [ERROR_WIDTH-1:0] ERR_FEEDER  = 3'd3;
    localparam logic [ERROR_WIDTH-1:0] ERR_SENSOR  = 3'd4;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEPPER_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRIPPER_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FEEDER_LIMIT  = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEPS         = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SAMPLE_EVERY  = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_PERIOD   = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETTLE        = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RETRY         = 3'd7;

    // Servo angles in degrees
    localparam logic [ANGLE_WIDTH-1:0] GRIP_OPEN_DEG   = 8'd80;
    localparam logic [ANGLE_WIDTH-1:0] GRIP_CLOSED_DEG = 8'd10;
    localparam logic [ANGLE_WIDTH-1:0] FEED_OPEN_DEG   = 8'd70;
    localparam logic [ANGLE_WIDTH-1:0] FEED_CLOSED_DEG = 8'd10;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_STEPPING,
        PH_RETRY
    } phase_t;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0]  stepper_limit;
        logic [LIMIT_WIDTH-1:0]  gripper_limit;
        logic [LIMIT_WIDTH-1:0]  feeder_limit;
        logic [STEPS_WIDTH-1:0]  steps_per_move;
        logic [STEPS_WIDTH-1:0]  sample_every;
        logic [PERIOD_WIDTH-1:0] step_period;
        logic [WAIT_WIDTH-1:0]   settle_ticks;
        logic [WAIT_WIDTH-1:0]   retry_ticks;
    } cfg_t;

    typedef struct packed {
        logic                   ack_valid;
        logic                   ack_ok;
        logic [ERROR_WIDTH-1:0] error_code;
        logic                   step_pulse;
        logic                   step_direction;
        logic                   driver_enable;
        logic [ANGLE_WIDTH-1:0] gripper_angle;
        logic [ANGLE_WIDTH-1:0] feeder_angle;
        logic                   busy_res;
        logic                   halted;
    } res_t;

endpackage

[rtl/core/actuator_overcurrent_sequencer_unit.sv]
// Channel  | Direction | Handshake            | Beat contents
// s_axis   | in        | s_tvalid / s_tready  | tuser action, tdata command, sense_ma
// m_axis   | out       | m_tvalid / m_tready  | tdata one result per input beat
// cfg      | in        | cfg_valid / cfg_ready| cfg_index register, cfg_data value
//
// One input beat per clock while the result drains; each beat passes through the input
// register, then the sequencer update into the result register.
// The sequencer state advances in the same cycle its result is registered.
// Reset (rst_n low, asynchronous) restores the register defaults, idle phase,
// both servos closed at 10 degrees and clears the halt.
// A stalled m_tready holds the result; the input register still takes one more
// beat, then s_tready drops until the result drains. cfg_ready is always high.
module actuator_overcurrent_sequencer_unit
    import acos_pkg::*;
#(
    parameter int STEP_INDEX_WIDTH = STEP_INDEX_WIDTH_DEF,
    parameter int TIMER_WIDTH      = TIMER_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [2:0] command, [18:3] sense_ma, [23:19] zero
    input  logic [23:0]                s_tdata,
    // [1:0] action
    input  logic [ACTION_WIDTH-1:0]    s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [0] ack_valid, [1] ack_ok, [4:2] error_code, [5] step_pulse,
    // [6] step_direction, [7] driver_enable, [15:8] gripper_angle,
    // [23:16] feeder_angle, [24] busy_res, [25] halted, [31:26] zero
    output logic [31:0]                m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t                     cfg;
    res_t                     res;
    res_t                     res_reg;
    logic                     out_valid_reg;
    logic                     in_valid_reg;
    logic [ACTION_WIDTH-1:0]  action_reg;
    logic [COMMAND_WIDTH-1:0] command_reg;
    logic [CURRENT_WIDTH-1:0] current_reg;
    logic                     advance;
    logic                     fire;

    assign cfg_ready = 1'b1;

    // Move the result register whenever it is empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    acos_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    acos_seq
    #(
        .STEP_INDEX_WIDTH (STEP_INDEX_WIDTH),
        .TIMER_WIDTH      (TIMER_WIDTH)
    )
    u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .action   (action_reg),
        .command  (command_reg),
        .sense_ma (current_reg),
        .cfg      (cfg),
        .res      (res)
    );

    // Input register: capture a beat whenever there is room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            action_reg  <= s_tuser;
            command_reg <= s_tdata[2:0];
            current_reg <= s_tdata[18:3];
        end
    end

    // Result register: load the sequencer output as the item retires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       res_reg.halted,
                       res_reg.busy_res,
                       res_reg.feeder_angle,
                       res_reg.gripper_angle,
                       res_reg.driver_enable,
                       res_reg.step_direction,
                       res_reg.step_pulse,
                       res_reg.error_code,
                       res_reg.ack_ok,
                       res_reg.ack_valid};

endmodule

[rtl/core/acos_cfg.sv]
module acos_cfg
    import acos_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stepper_limit  <= 15'd1500;
            cfg_reg.gripper_limit  <= 15'd800;
            cfg_reg.feeder_limit   <= 15'd800;
            cfg_reg.steps_per_move <= 10'd400;
            cfg_reg.sample_every   <= 10'd20;
            cfg_reg.step_period    <= 8'd16;
            cfg_reg.settle_ticks   <= 16'd3000;
            cfg_reg.retry_ticks    <= 16'd5000;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_STEPPER_LIMIT: cfg_reg.stepper_limit  <= wr_data[LIMIT_WIDTH-1:0];
                REG_GRIPPER_LIMIT: cfg_reg.gripper_limit  <= wr_data[LIMIT_WIDTH-1:0];
                REG_FEEDER_LIMIT:  cfg_reg.feeder_limit   <= wr_data[LIMIT_WIDTH-1:0];
                REG_STEPS:         cfg_reg.steps_per_move <= wr_data[STEPS_WIDTH-1:0];
                REG_SAMPLE_EVERY:  cfg_reg.sample_every   <= wr_data[STEPS_WIDTH-1:0];
                REG_STEP_PERIOD:   cfg_reg.step_period    <= wr_data[PERIOD_WIDTH-1:0];
                REG_SETTLE:        cfg_reg.settle_ticks   <= wr_data;
                REG_RETRY:         cfg_reg.retry_ticks    <= wr_data;
                default:           cfg_reg.retry_ticks    <= cfg_reg.retry_ticks;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/acos_seq.sv]
module acos_seq
    import acos_pkg::*;
#(
    parameter int STEP_INDEX_WIDTH = STEP_INDEX_WIDTH_DEF,
    parameter int TIMER_WIDTH      = TIMER_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  logic [ACTION_WIDTH-1:0]  action,
    input  logic [COMMAND_WIDTH-1:0] command,
    input  logic [CURRENT_WIDTH-1:0] sense_ma,
    input  cfg_t                     cfg,
    output res_t                     res
);

    localparam int CW = (STEP_INDEX_WIDTH > STEPS_WIDTH) ? STEP_INDEX_WIDTH : STEPS_WIDTH;
    localparam logic [CW-1:0] STEP_MAX =
        CW'((33'd1 << STEP_INDEX_WIDTH) - 33'd1);
    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_WIDTH) - 33'd1;

    phase_t                      phase_reg, phase_next;
    logic [COMMAND_WIDTH-1:0]    cmd_reg, cmd_next;
    logic                        retry_reg, retry_next;
    logic [STEP_INDEX_WIDTH-1:0] step_reg, step_next;
    logic [STEPS_WIDTH-1:0]      sample_reg, sample_next;
    logic [TIMER_WIDTH-1:0]      timer_reg, timer_next;
    logic                        halted_reg, halted_next;
    logic [ANGLE_WIDTH-1:0]      grip_reg, grip_next;
    logic [ANGLE_WIDTH-1:0]      feed_reg, feed_next;

    logic [PERIOD_WIDTH-1:0]     period;
    logic [STEPS_WIDTH-1:0]      every;
    logic [STEPS_WIDTH-1:0]      spm;
    logic [CW-1:0]               move_steps;
    logic [TIMER_WIDTH:0]        timer_inc;
    logic [STEPS_WIDTH:0]        sample_inc;
    logic [STEP_INDEX_WIDTH-1:0] step_inc;
    logic [LIMIT_WIDTH-1:0]      limit;
    logic [ERROR_WIDTH-1:0]      err_of_cmd;
    logic                        over_limit;
    logic                        over_stepper;
    logic                        do_launch;
    logic                        do_oc;
    logic                        ack_v;
    logic                        ack_ok;
    logic [ERROR_WIDTH-1:0]      err;

    function automatic logic [TIMER_WIDTH-1:0] cap_timer(input logic [WAIT_WIDTH-1:0] v);
        if ({17'd0, v} > TIMER_MAX)
            return TIMER_MAX[TIMER_WIDTH-1:0];
        else
            return TIMER_WIDTH'(v);
    endfunction

    function automatic logic is_stepper(input logic [COMMAND_WIDTH-1:0] c);
        return (c == CMD_STEP_DOWN) || (c == CMD_STEP_UP);
    endfunction

    function automatic logic is_gripper(input logic [COMMAND_WIDTH-1:0] c);
        return (c == CMD_GRIP_OPEN) || (c == CMD_GRIP_CLOSE);
    endfunction

    // Clamp degenerate register values
    assign period     = (cfg.step_period < 8'd2) ? 8'd2 : cfg.step_period;
    assign every      = (cfg.sample_every == '0) ? 10'd1 : cfg.sample_every;
    assign spm        = (cfg.steps_per_move == '0) ? 10'd1 : cfg.steps_per_move;
    assign move_steps = (CW'(spm) > STEP_MAX) ? STEP_MAX : CW'(spm);

    assign timer_inc  = {1'b0, timer_reg} + (TIMER_WIDTH+1)'(1);
    assign sample_inc = {1'b0, sample_reg} + 11'd1;
    assign step_inc   = step_reg + STEP_INDEX_WIDTH'(1);

    always_comb
    begin
        if (is_stepper(cmd_reg))
        begin
            limit      = cfg.stepper_limit;
            err_of_cmd = ERR_STEPPER;
        end
        else if (is_gripper(cmd_reg))
        begin
            limit      = cfg.gripper_limit;
            err_of_cmd = ERR_GRIPPER;
        end
        else
        begin
            limit      = cfg.feeder_limit;
            err_of_cmd = ERR_FEEDER;
        end
    end

    assign over_limit   = $signed(sense_ma) > $signed({1'b0, limit});
    assign over_stepper = $signed(sense_ma) > $signed({1'b0, cfg.stepper_limit});

    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        retry_next  = retry_reg;
        step_next   = step_reg;
        sample_next = sample_reg;
        timer_next  = timer_reg;
        halted_next = halted_reg;
        grip_next   = grip_reg;
        feed_next   = feed_reg;
        do_launch   = 1'b0;
        do_oc       = 1'b0;
        ack_v       = 1'b0;
        ack_ok      = 1'b0;
        err         = ERR_OK;

        unique case (action)
            ACT_COMMAND:
            begin
                if (phase_reg == PH_IDLE && !halted_reg &&
                    command != CMD_NONE && command <= CMD_STEP_UP)
                begin
                    cmd_next   = command;
                    retry_next = 1'b0;
                    do_launch  = 1'b1;
                end
            end
            ACT_TICK:
            begin
                unique case (phase_reg)
                    PH_SETTLE:
                    begin
                        if (timer_reg != '0)
                            timer_next = timer_reg - TIMER_WIDTH'(1);
                        else if (over_limit)
                            do_oc = 1'b1;
                        else
                        begin
                            phase_next = PH_IDLE;
                            ack_v      = 1'b1;
                            ack_ok     = 1'b1;
                        end
                    end
                    PH_STEPPING:
                    begin
                        if (timer_inc >= (TIMER_WIDTH+1)'(period))
                        begin
                            if (sample_reg == '0 && over_stepper)
                                do_oc = 1'b1;
                            else
                            begin
                                step_next   = step_inc;
                                timer_next  = '0;
                                sample_next = (sample_inc >= {1'b0, every}) ?
                                              '0 : sample_inc[STEPS_WIDTH-1:0];
                                if (CW'(step_inc) >= move_steps)
                                    phase_next = PH_SETTLE;
                            end
                        end
                        else
                            timer_next = timer_inc[TIMER_WIDTH-1:0];
                    end
                    PH_RETRY:
                    begin
                        if (timer_reg != '0)
                            timer_next = timer_reg - TIMER_WIDTH'(1);
                        else
                            do_launch = 1'b1;
                    end
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            ACT_FAULT:
            begin
                if (!halted_reg)
                begin
                    ack_v       = (phase_reg != PH_IDLE);
                    halted_next = 1'b1;
                    phase_next  = PH_IDLE;
                    err         = ERR_SENSOR;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // Restart the command from its first step
        if (do_launch)
        begin
            if (is_stepper(cmd_next))
            begin
                phase_next  = PH_STEPPING;
                step_next   = '0;
                sample_next = '0;
                timer_next  = '0;
            end
            else
            begin
                unique case (cmd_next)
                    CMD_GRIP_OPEN:  grip_next = GRIP_OPEN_DEG;
                    CMD_GRIP_CLOSE: grip_next = GRIP_CLOSED_DEG;
                    CMD_FEED_OPEN:  feed_next = FEED_OPEN_DEG;
                    default:        feed_next = FEED_CLOSED_DEG;
                endcase
                phase_next = PH_SETTLE;
                timer_next = cap_timer(cfg.settle_ticks);
            end
        end

        // Stop the motor: pause and retry once, then halt
        if (do_oc)
        begin
            if (!retry_reg)
            begin
                retry_next = 1'b1;
                phase_next = PH_RETRY;
                timer_next = cap_timer(cfg.retry_ticks);
            end
            else
            begin
                halted_next = 1'b1;
                phase_next  = PH_IDLE;
                ack_v       = 1'b1;
                err         = err_of_cmd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            cmd_reg    <= CMD_NONE;
            retry_reg  <= 1'b0;
            step_reg   <= '0;
            sample_reg <= '0;
            timer_reg  <= '0;
            halted_reg <= 1'b0;
            grip_reg   <= GRIP_CLOSED_DEG;
            feed_reg   <= FEED_CLOSED_DEG;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            cmd_reg    <= cmd_next;
            retry_reg  <= retry_next;
            step_reg   <= step_next;
            sample_reg <= sample_next;
            timer_reg  <= timer_next;
            halted_reg <= halted_next;
            grip_reg   <= grip_next;
            feed_reg   <= feed_next;
        end
    end

    // Report the state after the item
    always_comb
    begin
        res.ack_valid      = ack_v;
        res.ack_ok         = ack_ok;
        res.error_code     = err;
        res.step_pulse     = (phase_next == PH_STEPPING) &&
                             ({1'b0, timer_next} < (TIMER_WIDTH+1)'(period >> 1));
        res.step_direction = (cmd_next == CMD_STEP_DOWN);
        res.driver_enable  = (phase_next == PH_STEPPING);
        res.gripper_angle  = grip_next;
        res.feeder_angle   = feed_next;
        res.busy_res       = (phase_next != PH_IDLE);
        res.halted         = halted_next;
    end

endmodule

[bench/actuator_overcurrent_sequencer_unit_test.sv]
module actuator_overcurrent_sequencer_unit_test;
    import acos_pkg::*;

    // Generous run ceiling; the slowest correct run stays far below it.
    localparam int CYCLE_LIMIT  = 3_000_000;
    // Random beats per register setting.
    localparam int RANDOM_BEATS = 160;
    // Codes the block must ignore.
    localparam logic [ACTION_WIDTH-1:0]  ACT_UNDEFINED = 2'd3;
    localparam logic [COMMAND_WIDTH-1:0] CMD_UNDEFINED = 3'd7;

    // Tracks the sequencer state beat by beat and holds the status words
    // still owed by the block, oldest first.
    class sequencer_status;
        cfg_t                                regs;
        phase_t                              phase;
        logic [COMMAND_WIDTH-1:0]            active_cmd;
        bit                                  retry_used;
        logic [STEP_INDEX_WIDTH_DEF-1:0]     step_index;
        logic [TIMER_WIDTH_DEF-1:0]          tick_timer;
        bit                                  halted;
        logic [ANGLE_WIDTH-1:0]              gripper_pos;
        logic [ANGLE_WIDTH-1:0]              feeder_pos;
        res_t                                status_due[$];
        int                                  mismatch_count;

        function new();
            regs.stepper_limit  = 1500;
            regs.gripper_limit  = 800;
            regs.feeder_limit   = 800;
            regs.steps_per_move = 400;
            regs.sample_every   = 20;
            regs.step_period    = 16;
            regs.settle_ticks   = 3000;
            regs.retry_ticks    = 5000;
            phase          = PH_IDLE;
            active_cmd     = CMD_NONE;
            retry_used     = 1'b0;
            step_index     = '0;
            tick_timer     = '0;
            halted         = 1'b0;
            gripper_pos    = GRIP_CLOSED_DEG;
            feeder_pos     = FEED_CLOSED_DEG;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                                logic [CFG_DATA_WIDTH-1:0] val);
            case (idx)
                REG_STEPPER_LIMIT: regs.stepper_limit  = val[LIMIT_WIDTH-1:0];
                REG_GRIPPER_LIMIT: regs.gripper_limit  = val[LIMIT_WIDTH-1:0];
                REG_FEEDER_LIMIT:  regs.feeder_limit   = val[LIMIT_WIDTH-1:0];
                REG_STEPS:         regs.steps_per_move = val[STEPS_WIDTH-1:0];
                REG_SAMPLE_EVERY:  regs.sample_every   = val[STEPS_WIDTH-1:0];
                REG_STEP_PERIOD:   regs.step_period    = val[PERIOD_WIDTH-1:0];
                REG_SETTLE:        regs.settle_ticks   = val;
                REG_RETRY:         regs.retry_ticks    = val;
                default: ;
            endcase
        endfunction

        function bit is_stepper(logic [COMMAND_WIDTH-1:0] c);
            return c == CMD_STEP_DOWN || c == CMD_STEP_UP;
        endfunction

        function int limit_for(logic [COMMAND_WIDTH-1:0] c);
            if (is_stepper(c))
                return int'(regs.stepper_limit);
            if (c == CMD_GRIP_OPEN || c == CMD_GRIP_CLOSE)
                return int'(regs.gripper_limit);
            return int'(regs.feeder_limit);
        endfunction

        function logic [ERROR_WIDTH-1:0] error_for(logic [COMMAND_WIDTH-1:0] c);
            if (is_stepper(c))
                return ERR_STEPPER;
            if (c == CMD_GRIP_OPEN || c == CMD_GRIP_CLOSE)
                return ERR_GRIPPER;
            return ERR_FEEDER;
        endfunction

        // A zero step count still makes one step.
        function int move_steps();
            return (regs.steps_per_move == 0) ? 1 : int'(regs.steps_per_move);
        endfunction

        // Start (or restart) the active command from its first step.
        function void launch();
            if (is_stepper(active_cmd))
            begin
                phase      = PH_STEPPING;
                step_index = '0;
                tick_timer = '0;
            end
            else
            begin
                case (active_cmd)
                    CMD_GRIP_OPEN:  gripper_pos = GRIP_OPEN_DEG;
                    CMD_GRIP_CLOSE: gripper_pos = GRIP_CLOSED_DEG;
                    CMD_FEED_OPEN:  feeder_pos  = FEED_OPEN_DEG;
                    default:        feeder_pos  = FEED_CLOSED_DEG;
                endcase
                phase      = PH_SETTLE;
                tick_timer = regs.settle_ticks;
            end
        endfunction

        // First overcurrent pauses for a retry, the second one halts for good.
        function void trip(inout res_t r);
            if (!retry_used)
            begin
                retry_used = 1'b1;
                phase      = PH_RETRY;
                tick_timer = regs.retry_ticks;
            end
            else
            begin
                halted       = 1'b1;
                phase        = PH_IDLE;
                r.ack_valid  = 1'b1;
                r.error_code = error_for(active_cmd);
            end
        endfunction

        // Advance the state by one accepted beat and queue the status it owes.
        function void record_event(logic [ACTION_WIDTH-1:0] act,
                                   logic [COMMAND_WIDTH-1:0] cmd,
                                   logic [CURRENT_WIDTH-1:0] raw);
            res_t r;
            int   cur;
            int   per;
            int   every;
            int   t;
            cur   = int'($signed(raw));
            per   = (regs.step_period < 2) ? 2 : int'(regs.step_period);
            every = (regs.sample_every == 0) ? 1 : int'(regs.sample_every);
            r     = '0;
            case (act)
                ACT_COMMAND:
                begin
                    if (phase == PH_IDLE && !halted &&
                        cmd >= CMD_GRIP_OPEN && cmd <= CMD_STEP_UP)
                    begin
                        active_cmd = cmd;
                        retry_used = 1'b0;
                        launch();
                    end
                end
                ACT_TICK:
                begin
                    case (phase)
                        PH_SETTLE:
                        begin
                            if (tick_timer != 0)
                                tick_timer = tick_timer - 1'b1;
                            else if (cur > limit_for(active_cmd))
                                trip(r);
                            else
                            begin
                                phase      = PH_IDLE;
                                r.ack_valid = 1'b1;
                                r.ack_ok    = 1'b1;
                            end
                        end
                        PH_STEPPING:
                        begin
                            t = int'(tick_timer) + 1;
                            if (t >= per)
                            begin
                                if ((int'(step_index) % every) == 0 &&
                                    cur > int'(regs.stepper_limit))
                                    trip(r);
                                else
                                begin
                                    step_index = step_index + 1'b1;
                                    tick_timer = '0;
                                    if (int'(step_index) >= move_steps())
                                        phase = PH_SETTLE;
                                end
                            end
                            else
                                tick_timer = t[TIMER_WIDTH_DEF-1:0];
                        end
                        PH_RETRY:
                        begin
                            if (tick_timer != 0)
                                tick_timer = tick_timer - 1'b1;
                            else
                                launch();
                        end
                        default: ;
                    endcase
                end
                ACT_FAULT:
                begin
                    if (!halted)
                    begin
                        if (phase != PH_IDLE)
                            r.ack_valid = 1'b1;
                        halted       = 1'b1;
                        phase        = PH_IDLE;
                        r.error_code = ERR_SENSOR;
                    end
                end
                default: ;
            endcase
            r.step_pulse     = phase == PH_STEPPING && int'(tick_timer) < (per >> 1);
            r.step_direction = active_cmd == CMD_STEP_DOWN;
            r.driver_enable  = phase == PH_STEPPING;
            r.gripper_angle  = gripper_pos;
            r.feeder_angle   = feeder_pos;
            r.busy_res       = phase != PH_IDLE;
            r.halted         = halted;
            status_due.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        // Unpack one result beat and check it against the oldest status owed.
        function void compare_status(logic [31:0] d);
            res_t want;
            if (status_due.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time, d);
                mismatch_count++;
                return;
            end
            want = status_due.pop_front();
            compare_field("ack_valid",      want.ack_valid,      d[0]);
            compare_field("ack_ok",         want.ack_ok,         d[1]);
            compare_field("error_code",     want.error_code,     d[4:2]);
            compare_field("step_pulse",     want.step_pulse,     d[5]);
            compare_field("step_direction", want.step_direction, d[6]);
            compare_field("driver_enable",  want.driver_enable,  d[7]);
            compare_field("gripper_angle",  want.gripper_angle,  d[15:8]);
            compare_field("feeder_angle",   want.feeder_angle,   d[23:16]);
            compare_field("busy_res",       want.busy_res,       d[24]);
            compare_field("halted",         want.halted,         d[25]);
            compare_field("padding",        0,                   d[31:26]);
        endfunction
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    // [2:0] command, [18:3] sense_ma, [23:19] zero
    logic [23:0]                s_tdata   = '0;
    // [1:0] action
    logic [ACTION_WIDTH-1:0]    s_tuser   = ACT_COMMAND;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    // [0] ack_valid, [1] ack_ok, [4:2] error_code, [5] step_pulse,
    // [6] step_direction, [7] driver_enable, [15:8] gripper_angle,
    // [23:16] feeder_angle, [24] busy_res, [25] halted, [31:26] zero
    logic [31:0]                m_tdata;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_STEPPER_LIMIT;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    sequencer_status status = new();
    int sender_idle_pct   = 25;
    int receiver_idle_pct = 79;
    int cycle_count       = 0;

    actuator_overcurrent_sequencer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4-unit clock: high for 2, low for 2.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Watchdog: a hung handshake or a lost result ends up here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stall the result side at random; drive at the falling edge only.
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);

    // Check every result beat taken at the rising edge.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            status.compare_status(m_tdata);

    // Present one input beat and hold it until accepted. Enter and leave at a
    // falling edge; tvalid stays high on return so the next beat can follow
    // without a bubble. Call stop_sending before waiting on anything else.
    task automatic send_beat(input logic [ACTION_WIDTH-1:0] act,
                             input logic [COMMAND_WIDTH-1:0] cmd,
                             input logic [CURRENT_WIDTH-1:0] cur);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'd0, cur, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        status.record_event(act, cmd, cur);
        @(negedge clk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // Drop tvalid, wait for every owed result, then let the pipe settle.
    task automatic wait_results();
        stop_sending();
        while (status.status_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Tick with a negative current, which never exceeds a limit, until the
    // running command is done.
    task automatic drain_to_idle();
        while (status.phase != PH_IDLE)
            send_beat(ACT_TICK, 3'($urandom), {1'b1, 15'($urandom)});
    endtask

    // Hold one sample until the command trips or finishes.
    task automatic tick_until_trip(input logic [CURRENT_WIDTH-1:0] cur);
        while (!status.retry_used && status.phase != PH_IDLE)
            send_beat(ACT_TICK, CMD_NONE, cur);
    endtask

    // One register beat; leaves cfg_valid high for the next one.
    task automatic put_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        status.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] stepper_lim, input logic [15:0] gripper_lim,
                                  input logic [15:0] feeder_lim, input logic [15:0] steps,
                                  input logic [15:0] every, input logic [15:0] period,
                                  input logic [15:0] settle, input logic [15:0] retry);
        put_reg(REG_STEPPER_LIMIT, stepper_lim);
        put_reg(REG_GRIPPER_LIMIT, gripper_lim);
        put_reg(REG_FEEDER_LIMIT,  feeder_lim);
        put_reg(REG_STEPS,         steps);
        put_reg(REG_SAMPLE_EVERY,  every);
        put_reg(REG_STEP_PERIOD,   period);
        put_reg(REG_SETTLE,        settle);
        put_reg(REG_RETRY,         retry);
        cfg_valid <= 1'b0;
    endtask

    // Sample for the active motor: mostly within limit, sometimes exactly at
    // it, and over it only while a retry is still available so the random
    // part never halts the block.
    function automatic logic [CURRENT_WIDTH-1:0] pick_current();
        int lim;
        int roll;
        lim  = status.limit_for(status.active_cmd);
        roll = $urandom_range(0, 99);
        if (!status.retry_used && lim < 32767 && roll < 20)
            return (roll < 6) ? 16'(lim + 1) : 16'($urandom_range(lim + 1, 32767));
        if (roll < 30)
            return 16'(lim);
        return 16'(int'($urandom_range(0, lim + 32768)) - 32768);
    endfunction

    // Mostly well-formed traffic steered by the tracked phase: commands when
    // idle, ticks while busy, with a little noise (ignored codes, busy
    // commands, idle ticks). Sensor faults are kept for the very end.
    task automatic random_beat();
        logic [ACTION_WIDTH-1:0]  act;
        logic [COMMAND_WIDTH-1:0] cmd;
        int                       roll;
        roll = $urandom_range(0, 99);
        cmd  = 3'($urandom);
        if (roll < 3)
            act = ACT_UNDEFINED;
        else if (status.phase == PH_IDLE)
        begin
            if (roll < 10)
                act = ACT_TICK;
            else
            begin
                act = ACT_COMMAND;
                if (roll < 85)
                    cmd = 3'($urandom_range(CMD_GRIP_OPEN, CMD_STEP_UP));
            end
        end
        else
            act = (roll < 8) ? ACT_COMMAND : ACT_TICK;
        send_beat(act, cmd, pick_current());
    endtask

    task automatic run_random(input int beats);
        repeat (beats) random_beat();
        drain_to_idle();
        wait_results();
    endtask

    initial
    begin
        int ending;
        ending = $urandom_range(0, 2);

        // Reset once, then release it.
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- Directed, register defaults: ignored codes and idle ticks, then
        // a stepper move at the default period, step count and sampling with
        // a sample equal to the default limit. A second command while busy is
        // dropped. The move is then cut short through the step count, which
        // is read live, so the run stays short.
        send_beat(ACT_TICK,      CMD_NONE,      16'h7FFF);
        send_beat(ACT_UNDEFINED, CMD_GRIP_OPEN, 16'h8000);
        send_beat(ACT_COMMAND,   CMD_NONE,      16'h0000);
        send_beat(ACT_COMMAND,   CMD_UNDEFINED, 16'hFFFF);
        send_beat(ACT_COMMAND,   CMD_STEP_DOWN, 16'h0000);
        send_beat(ACT_COMMAND,   CMD_FEED_OPEN, 16'h0000);
        repeat (40)
            send_beat(ACT_TICK, CMD_NONE, 16'd1500);
        wait_results();
        put_reg(REG_STEPS, 16'd3);
        cfg_valid <= 1'b0;
        drain_to_idle();
        wait_results();

        // --- Directed, short settings: every command trips once at full-scale
        // current, retries and then succeeds; then a sample equal to the
        // limit, which must not count as overcurrent.
        apply_settings(16'd1000, 16'd600, 16'd700, 16'd4, 16'd2, 16'd3, 16'd2, 16'd3);
        for (int c = CMD_GRIP_OPEN; c <= CMD_STEP_UP; c++)
        begin
            send_beat(ACT_COMMAND, 3'(c), 16'h0000);
            tick_until_trip(16'h7FFF);
            drain_to_idle();
        end
        send_beat(ACT_COMMAND, CMD_GRIP_CLOSE, 16'h0000);
        tick_until_trip(16'(status.regs.gripper_limit));
        send_beat(ACT_COMMAND, CMD_STEP_UP, 16'h0000);
        tick_until_trip(16'(status.regs.stepper_limit));
        drain_to_idle();
        wait_results();
        run_random(RANDOM_BEATS);

        // Zero limits, single step, no waits.
        apply_settings(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd2, 16'd0, 16'd0);
        run_random(RANDOM_BEATS);
        // Full-scale limits: no sample can exceed them.
        apply_settings(16'd32767, 16'd32767, 16'd32767, 16'd5, 16'd1023, 16'd4, 16'd1, 16'd1);
        run_random(RANDOM_BEATS);

        // --- Sender mostly idle, receiver mostly ready.
        sender_idle_pct   = 79;
        receiver_idle_pct = 25;
        // Degenerate step count, sample spacing and period.
        apply_settings(16'd200, 16'd300, 16'd100, 16'd0, 16'd0, 16'd1, 16'd3, 16'd2);
        run_random(RANDOM_BEATS);
        // Upper data bits beyond each register's width must be dropped.
        apply_settings(16'h8064, 16'hFFFF, 16'h8000, 16'hFC03, 16'h0402, 16'h0100,
                       16'd4, 16'd5);
        run_random(RANDOM_BEATS);
        // Slowest step period, one step per move.
        apply_settings(16'd1500, 16'd800, 16'd800, 16'd1, 16'd3, 16'd255, 16'd2, 16'd1);
        run_random(RANDOM_BEATS);

        // --- No idling on either side.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        // Long move, sparsest sampling, longer settle and retry waits.
        apply_settings(16'd400, 16'd800, 16'd800, 16'd40, 16'd1023, 16'd2,
                       16'd60, 16'd60);
        run_random(RANDOM_BEATS);
        apply_settings(16'd1200, 16'd500, 16'd400, 16'd3, 16'd2, 16'd2, 16'd1, 16'd2);
        run_random(RANDOM_BEATS);

        // --- Halt, last since only reset clears it: a sensor fault during a
        // command, a sensor fault while idle, or a second overcurrent.
        case (ending)
            0:
            begin
                send_beat(ACT_COMMAND, 3'($urandom_range(CMD_GRIP_OPEN, CMD_STEP_UP)),
                          16'h0000);
                send_beat(ACT_TICK, CMD_NONE, 16'h0000);
                send_beat(ACT_FAULT, CMD_NONE, 16'h0000);
            end
            1:
                send_beat(ACT_FAULT, CMD_NONE, 16'h0000);
            default:
            begin
                send_beat(ACT_COMMAND, 3'($urandom_range(CMD_GRIP_OPEN, CMD_STEP_UP)),
                          16'h0000);
                while (!status.halted)
                    send_beat(ACT_TICK, CMD_NONE, 16'h7FFF);
            end
        endcase
        // Once halted: faults, commands and ticks change nothing.
        send_beat(ACT_FAULT,     CMD_NONE,      16'h0000);
        send_beat(ACT_COMMAND,   CMD_STEP_DOWN, 16'h0000);
        send_beat(ACT_TICK,      CMD_NONE,      16'h7FFF);
        send_beat(ACT_UNDEFINED, CMD_FEED_OPEN, 16'h8000);
        wait_results();

        if (status.mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/acos_pkg.sv
rtl/core/acos_cfg.sv
rtl/core/acos_seq.sv
rtl/core/actuator_overcurrent_sequencer_unit.sv
bench/actuator_overcurrent_sequencer_unit_test.sv
